FILE: rtl/core/upnm_pkg.sv
`default_nettype none
package upnm_pkg;

    // field widths fixed by the interface
    localparam int TAB_W   = 1;
    localparam int IDX_W   = 5;
    localparam int POS_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int MIDX_W  = 5;
    localparam int USED_W  = 6;
    localparam int CFG_IDX_W = 1;

    // input item kinds
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // match kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXACT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PREFIX = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_USED    = 1'b1;

    localparam logic [USED_W-1:0] USED_RESET = 6'd32;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

    typedef struct packed {
        logic load_wr;      // write one table byte
        logic latch_query;  // capture query character, advance position
        logic rd_en;        // read one entry at the current position
        logic eval;         // read data valid: update entry flag
        logic decide;       // eval on the final character
        logic load_out;     // load result register and rearm
    } t_dp_cmd;

endpackage
`default_nettype wire

FILE: rtl/core/upnm_ctrl.sv
`default_nettype none
module upnm_ctrl #(
    parameter int ENTRIES = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire                       i_command,
    input  wire                       i_last_char,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output upnm_pkg::t_dp_cmd         o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_rd_entry
);

    localparam int EW = $clog2(ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [EW-1:0] r_cnt, n_cnt;
    logic          r_eval_v;
    logic          r_last, n_last;
    logic          r_out_valid, n_out_valid;
    logic          in_acc;
    logic          out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rd_entry  = r_cnt;

    always_comb begin
        o_cmd.load_wr     = in_acc && (i_command == upnm_pkg::CMD_LOAD);
        o_cmd.latch_query = in_acc && (i_command == upnm_pkg::CMD_QUERY);
        o_cmd.rd_en       = (r_state == S_RUN);
        o_cmd.eval        = r_eval_v;
        o_cmd.decide      = r_eval_v && r_last;
        o_cmd.load_out    = (r_state == S_FIN) && out_free;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.latch_query) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                    n_last  = i_last_char;
                end
            end
            S_RUN: begin
                if (r_cnt == EW'(ENTRIES - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + EW'(1);
                end
            end
            S_DRAIN: begin
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_eval_v    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_eval_v    <= o_cmd.rd_en;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/upnm_dp.sv
`default_nettype none
module upnm_dp #(
    parameter int ENTRIES  = 32,
    parameter int NAME_LEN = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  upnm_pkg::t_dp_cmd                    i_cmd,
    input  wire [$clog2(ENTRIES)-1:0]            i_rd_entry,
    input  wire                                  i_cfg_we,
    input  wire [upnm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [upnm_pkg::USED_W-1:0]           i_cfg_data,
    input  wire [upnm_pkg::TAB_W-1:0]            i_table_sel,
    input  wire [upnm_pkg::IDX_W-1:0]            i_entry_index,
    input  wire [upnm_pkg::POS_W-1:0]            i_char_position,
    input  wire [upnm_pkg::CHAR_W-1:0]           i_char_value,
    output logic [upnm_pkg::KIND_W-1:0]          o_match_kind,
    output logic [upnm_pkg::MIDX_W-1:0]          o_match_index
);

    localparam int EW    = $clog2(ENTRIES);
    localparam int PW    = $clog2(NAME_LEN);
    localparam int QW    = $clog2(NAME_LEN + 1);
    localparam int AW    = upnm_pkg::TAB_W + EW + PW;
    localparam int DEPTH = 1 << AW;

    logic [upnm_pkg::CHAR_W-1:0] mem [0:DEPTH-1];

    logic [upnm_pkg::USED_W-1:0] r_cmd_used, r_item_used;
    logic [upnm_pkg::TAB_W-1:0]  r_tab;
    logic [upnm_pkg::CHAR_W-1:0] r_ch;
    logic [QW-1:0]               r_qpos, r_p;
    logic [upnm_pkg::CHAR_W-1:0] r_s, r_t;
    logic [EW-1:0]               r_ev_e;
    logic [ENTRIES-1:0]          r_flag;
    logic                        r_exact_hit;
    logic [EW-1:0]               r_exact_at, r_pref_at;
    logic [1:0]                  r_pcnt;
    logic [upnm_pkg::KIND_W-1:0] r_kind;
    logic [upnm_pkg::MIDX_W-1:0] r_midx;

    logic          wr_ok;
    logic [AW-1:0] wr_addr, rd_addr_s, rd_addr_t;
    logic          p_ok, tail_end;
    logic          new_flag, ends, in_used;
    logic [upnm_pkg::USED_W-1:0] used_sel;

    assign wr_ok   = (32'(i_entry_index) < ENTRIES) && (32'(i_char_position) < NAME_LEN);
    assign wr_addr = {i_table_sel, EW'(i_entry_index), PW'(i_char_position)};

    assign rd_addr_s = {r_tab, i_rd_entry, PW'(r_p)};
    assign rd_addr_t = {r_tab, i_rd_entry, PW'(r_p + QW'(1))};

    assign p_ok     = 32'(r_p) < NAME_LEN;
    assign tail_end = (32'(r_p) + 32'd1) >= NAME_LEN;

    // flag of the entry under evaluation sits at the bottom of the ring
    assign new_flag = r_flag[0] && p_ok && (r_s != upnm_pkg::NUL_CHAR) && (r_s == r_ch);
    assign ends     = tail_end || (r_t == upnm_pkg::NUL_CHAR);
    assign used_sel = r_tab[0] ? r_item_used : r_cmd_used;
    assign in_used  = 32'(r_ev_e) < 32'(used_sel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_ok) begin
            mem[wr_addr] <= i_char_value;
        end
        if (i_cmd.rd_en) begin
            r_s    <= mem[rd_addr_s];
            r_t    <= mem[rd_addr_t];
            r_ev_e <= i_rd_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_used  <= upnm_pkg::USED_RESET;
            r_item_used <= upnm_pkg::USED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                upnm_pkg::CFG_COMMAND_USED: r_cmd_used  <= i_cfg_data;
                upnm_pkg::CFG_ITEM_USED:    r_item_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_query) begin
            r_tab <= i_table_sel;
            r_ch  <= i_char_value;
            r_p   <= r_qpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpos <= '0;
            r_flag <= '1;
        end else if (i_cmd.load_out) begin
            r_qpos <= '0;
            r_flag <= '1;
        end else begin
            if (i_cmd.latch_query && (32'(r_qpos) < NAME_LEN)) begin
                r_qpos <= r_qpos + QW'(1);
            end
            if (i_cmd.eval) begin
                // after ENTRIES shifts every flag is back in place
                r_flag <= {new_flag, r_flag[ENTRIES-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_query) begin
            r_exact_hit <= 1'b0;
            r_pcnt      <= 2'd0;
            r_exact_at  <= '0;
            r_pref_at   <= '0;
        end else if (i_cmd.decide && new_flag && in_used && !r_exact_hit) begin
            if (ends) begin
                r_exact_hit <= 1'b1;
                r_exact_at  <= r_ev_e;
            end else begin
                if (r_pcnt != 2'd2) begin
                    r_pcnt <= r_pcnt + 2'd1;
                end
                r_pref_at <= r_ev_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_exact_hit) begin
                r_kind <= upnm_pkg::KIND_EXACT;
                r_midx <= upnm_pkg::MIDX_W'(r_exact_at);
            end else if (r_pcnt == 2'd1) begin
                r_kind <= upnm_pkg::KIND_PREFIX;
                r_midx <= upnm_pkg::MIDX_W'(r_pref_at);
            end else begin
                r_kind <= upnm_pkg::KIND_NONE;
                r_midx <= '0;
            end
        end
    end

    assign o_match_kind  = r_kind;
    assign o_match_index = r_midx;

endmodule
`default_nettype wire

FILE: rtl/core/unique_prefix_name_matcher_core.sv
// Load item: written straight into the name memory.
// Query character: one entry read per cycle from the name memory, then a drain state;
// the final character adds a finish state, and its result is loaded into an output
// register that holds it until taken.
// Reset (synchronous, active low): all match flags set, query position zero,
// both used counts 32; name memory contents undefined until written.
`default_nettype none
module unique_prefix_name_matcher_core #(
    parameter int ENTRIES  = 32,
    parameter int NAME_LEN = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_command,
    input  wire [upnm_pkg::TAB_W-1:0]            i_table_sel,
    input  wire [upnm_pkg::IDX_W-1:0]            i_entry_index,
    input  wire [upnm_pkg::POS_W-1:0]            i_char_position,
    input  wire [upnm_pkg::CHAR_W-1:0]           i_char_value,
    input  wire                                  i_last_char,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [upnm_pkg::KIND_W-1:0]          o_match_kind,
    output logic [upnm_pkg::MIDX_W-1:0]          o_match_index,
    input  wire                                  i_cfg_we,
    input  wire [upnm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [upnm_pkg::USED_W-1:0]           i_cfg_data
);

    upnm_pkg::t_dp_cmd          cmd;
    logic [$clog2(ENTRIES)-1:0] rd_entry;

    upnm_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_rd_entry  (rd_entry)
    );

    upnm_dp #(
        .ENTRIES  (ENTRIES),
        .NAME_LEN (NAME_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_entry      (rd_entry),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_table_sel     (i_table_sel),
        .i_entry_index   (i_entry_index),
        .i_char_position (i_char_position),
        .i_char_value    (i_char_value),
        .o_match_kind    (o_match_kind),
        .o_match_index   (o_match_index)
    );

endmodule
`default_nettype wire

FILE: sim/name_match_checker.sv
`default_nettype none
module name_match_checker #(
    parameter int ENTRIES  = 32,
    parameter int NAME_LEN = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 i_in_stall,
    input  wire                                 i_command,
    input  wire [upnm_pkg::TAB_W-1:0]           i_table_sel,
    input  wire [upnm_pkg::IDX_W-1:0]           i_entry_index,
    input  wire [upnm_pkg::POS_W-1:0]           i_char_position,
    input  wire [upnm_pkg::CHAR_W-1:0]          i_char_value,
    input  wire                                 i_last_char,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_stall,
    input  wire [upnm_pkg::KIND_W-1:0]          i_match_kind,
    input  wire [upnm_pkg::MIDX_W-1:0]          i_match_index,
    input  wire                                 i_cfg_we,
    input  wire [upnm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [upnm_pkg::USED_W-1:0]          i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_answers,
    output int                                  o_exact,
    output int                                  o_prefix,
    output int                                  o_none
);

    typedef struct packed {
        logic [upnm_pkg::KIND_W-1:0] kind;
        logic [upnm_pkg::MIDX_W-1:0] index;
    } t_answer;

    logic [upnm_pkg::CHAR_W-1:0] name_mem [2][ENTRIES][NAME_LEN];
    logic                        alive [ENTRIES];
    int                          qpos;
    logic [upnm_pkg::USED_W-1:0] used_cmd;
    logic [upnm_pkg::USED_W-1:0] used_item;
    t_answer                     answers_due [$];
    t_answer                     got;
    t_answer                     want;
    int                          fails;
    int                          n_answers;
    int                          n_exact;
    int                          n_prefix;
    int                          n_none;

    // Narrow the surviving entries by one query character; on the final
    // character pick the answer and rearm the flags.
    function automatic bit lookup_char(input logic tab,
                                       input logic [upnm_pkg::CHAR_W-1:0] ch,
                                       input logic last, output t_answer ans);
        int p;
        int limit;
        int prefixes;
        int prefix_at;
        bit ends;
        p = qpos;
        prefixes = 0;
        prefix_at = 0;
        ans.kind = upnm_pkg::KIND_NONE;
        ans.index = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (alive[e] && (p >= NAME_LEN || name_mem[tab][e][p] == upnm_pkg::NUL_CHAR ||
                             name_mem[tab][e][p] != ch))
                alive[e] = 1'b0;
        end
        if (qpos < NAME_LEN)
            qpos++;
        if (!last)
            return 1'b0;
        limit = tab ? used_item : used_cmd;
        if (limit > ENTRIES)
            limit = ENTRIES;
        for (int e = 0; e < limit; e++) begin
            if (alive[e] && ans.kind == upnm_pkg::KIND_NONE) begin
                // survivor means p < NAME_LEN, so p+1 is in range when read
                ends = (p + 1 >= NAME_LEN) ||
                       (name_mem[tab][e][p + 1] == upnm_pkg::NUL_CHAR);
                if (ends) begin
                    ans.kind = upnm_pkg::KIND_EXACT;
                    ans.index = upnm_pkg::MIDX_W'(e);
                end else begin
                    prefixes++;
                    prefix_at = e;
                end
            end
        end
        if (ans.kind == upnm_pkg::KIND_NONE && prefixes == 1) begin
            ans.kind = upnm_pkg::KIND_PREFIX;
            ans.index = upnm_pkg::MIDX_W'(prefix_at);
        end
        foreach (alive[e]) alive[e] = 1'b1;
        qpos = 0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (name_mem[t, e, p]) name_mem[t][e][p] = upnm_pkg::NUL_CHAR;
            foreach (alive[e]) alive[e] = 1'b1;
            qpos = 0;
            used_cmd = upnm_pkg::USED_RESET;
            used_item = upnm_pkg::USED_RESET;
            fails = 0;
            n_answers = 0;
            n_exact = 0;
            n_prefix = 0;
            n_none = 0;
            answers_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected answer: kind %0d index %0d",
                                 i_match_kind, i_match_index);
                end else begin
                    want = answers_due.pop_front();
                    n_answers++;
                    case (want.kind)
                        upnm_pkg::KIND_EXACT:  n_exact++;
                        upnm_pkg::KIND_PREFIX: n_prefix++;
                        default:               n_none++;
                    endcase
                    if (i_match_kind !== want.kind || i_match_index !== want.index) begin
                        fails++;
                        if (fails <= 10)
                            $display("answer %0d: want kind %0d index %0d, got kind %0d index %0d",
                                     n_answers, want.kind, want.index,
                                     i_match_kind, i_match_index);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == upnm_pkg::CFG_COMMAND_USED)
                    used_cmd = i_cfg_data;
                else if (i_cfg_index == upnm_pkg::CFG_ITEM_USED)
                    used_item = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == upnm_pkg::CMD_LOAD) begin
                    if (i_entry_index < ENTRIES && i_char_position < NAME_LEN)
                        name_mem[i_table_sel][i_entry_index][i_char_position] = i_char_value;
                end else if (lookup_char(i_table_sel, i_char_value, i_last_char, got)) begin
                    answers_due.push_back(got);
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= answers_due.size();
        o_answers <= n_answers;
        o_exact <= n_exact;
        o_prefix <= n_prefix;
        o_none <= n_none;
    end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none
module testbench;

    localparam int ENTRIES      = 32;
    localparam int NAME_LEN     = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = ENTRIES + 8;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 command;
    logic [upnm_pkg::TAB_W-1:0]           table_sel;
    logic [upnm_pkg::IDX_W-1:0]           entry_index;
    logic [upnm_pkg::POS_W-1:0]           char_position;
    logic [upnm_pkg::CHAR_W-1:0]          char_value;
    logic                                 last_char;
    logic                                 out_valid;
    logic                                 out_stall;
    logic [upnm_pkg::KIND_W-1:0]          match_kind;
    logic [upnm_pkg::MIDX_W-1:0]          match_index;
    logic                                 cfg_we;
    logic [upnm_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [upnm_pkg::USED_W-1:0]          cfg_data;

    int fail_count;
    int pending;
    int n_answers;
    int n_exact;
    int n_prefix;
    int n_none;

    // stimulus-side copy of the tables, used only to aim queries at stored names
    logic [upnm_pkg::CHAR_W-1:0] names [2][ENTRIES][NAME_LEN];
    logic [upnm_pkg::CHAR_W-1:0] ebytes [NAME_LEN];
    logic [upnm_pkg::CHAR_W-1:0] q_chars [$];
    logic                        q_sels [$];
    bit                          gaps_on;
    int                          cycle_cnt = 0;
    int                          n_items;
    int                          n_loads;
    int                          n_qchars;
    int                          n_settings;

    unique_prefix_name_matcher_core #(
        .ENTRIES  (ENTRIES),
        .NAME_LEN (NAME_LEN)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (command),
        .i_table_sel     (table_sel),
        .i_entry_index   (entry_index),
        .i_char_position (char_position),
        .i_char_value    (char_value),
        .i_last_char     (last_char),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_match_kind    (match_kind),
        .o_match_index   (match_index),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    name_match_checker #(
        .ENTRIES  (ENTRIES),
        .NAME_LEN (NAME_LEN)
    ) u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (command),
        .i_table_sel     (table_sel),
        .i_entry_index   (entry_index),
        .i_char_position (char_position),
        .i_char_value    (char_value),
        .i_last_char     (last_char),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_match_kind    (match_kind),
        .i_match_index   (match_index),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_answers       (n_answers),
        .o_exact         (n_exact),
        .o_prefix        (n_prefix),
        .o_none          (n_none)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d answers outstanding", cycle_cnt, pending);
        $display("status: fail");
        $finish;
    end

    // result side back-pressure in random bursts
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int stored_len(input int t, input int e);
        int n;
        n = 0;
        while (n < NAME_LEN && names[t][e][n] != upnm_pkg::NUL_CHAR)
            n++;
        return n;
    endfunction

    function automatic logic [upnm_pkg::CHAR_W-1:0] pick_char();
        logic [upnm_pkg::CHAR_W-1:0] c;
        if ($urandom_range(0, 4) == 0)
            c = upnm_pkg::CHAR_W'($urandom_range(1, 255));
        else
            c = upnm_pkg::CHAR_W'("a" + $urandom_range(0, 3));
        return c;
    endfunction

    // one transfer on the item channel; valid stays up afterwards
    task automatic put_item(input logic cmd, input logic tab,
                            input logic [upnm_pkg::IDX_W-1:0] idx,
                            input logic [upnm_pkg::POS_W-1:0] pos,
                            input logic [upnm_pkg::CHAR_W-1:0] ch,
                            input logic last);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        table_sel <= tab;
        entry_index <= idx;
        char_position <= pos;
        char_value <= ch;
        last_char <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
    endtask

    task automatic put_load(input logic tab, input int e, input int p,
                            input logic [upnm_pkg::CHAR_W-1:0] v);
        names[tab][e][p] = v;
        n_loads++;
        put_item(upnm_pkg::CMD_LOAD, tab, upnm_pkg::IDX_W'(e), upnm_pkg::POS_W'(p), v,
                 1'($urandom_range(0, 1)));
    endtask

    task automatic random_load();
        logic t;
        int e;
        int p;
        logic [upnm_pkg::CHAR_W-1:0] v;
        t = 1'($urandom_range(0, 1));
        e = $urandom_range(0, ENTRIES - 1);
        p = $urandom_range(0, NAME_LEN - 1);
        if ($urandom_range(0, 4) == 0)
            v = upnm_pkg::NUL_CHAR;
        else
            v = upnm_pkg::CHAR_W'($urandom_range(1, 255));
        put_load(t, e, p, v);
    endtask

    task automatic write_entry(input logic t, input int e, input int n);
        for (int p = 0; p < n; p++)
            put_load(t, e, p, ebytes[p]);
    endtask

    // terminator after the text, random junk behind it
    task automatic fill_text(input string s);
        for (int p = 0; p < NAME_LEN; p++) begin
            if (p < s.len())
                ebytes[p] = s[p];
            else if (p == s.len())
                ebytes[p] = upnm_pkg::NUL_CHAR;
            else
                ebytes[p] = upnm_pkg::CHAR_W'($urandom_range(0, 255));
        end
    endtask

    task automatic random_name(output int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 4);
        else if (r < 82)
            len = NAME_LEN;
        else if (r < 95)
            len = $urandom_range(1, 6);
        else
            len = 0;
        for (int p = 0; p < NAME_LEN; p++) begin
            if (p < len)
                ebytes[p] = (r >= 82) ? upnm_pkg::CHAR_W'($urandom_range(1, 255))
                                      : upnm_pkg::CHAR_W'("a" + $urandom_range(0, 3));
            else if (p == len)
                ebytes[p] = upnm_pkg::NUL_CHAR;
            else
                ebytes[p] = upnm_pkg::CHAR_W'($urandom_range(0, 255));
        end
    endtask

    task automatic put_query();
        for (int k = 0; k < q_chars.size(); k++) begin
            // table writes may fall between query characters
            if (k > 0 && $urandom_range(0, 29) == 0)
                random_load();
            put_item(upnm_pkg::CMD_QUERY, q_sels[k],
                     upnm_pkg::IDX_W'($urandom_range(0, ENTRIES - 1)),
                     upnm_pkg::POS_W'($urandom_range(0, NAME_LEN - 1)),
                     q_chars[k], k == q_chars.size() - 1);
            n_qchars++;
        end
    endtask

    task automatic query_text(input logic t, input string s);
        q_chars.delete();
        q_sels.delete();
        for (int k = 0; k < s.len(); k++) begin
            q_chars.push_back(s[k]);
            q_sels.push_back(t);
        end
        put_query();
    endtask

    task automatic query_byte(input logic t, input logic [upnm_pkg::CHAR_W-1:0] c);
        q_chars.delete();
        q_sels.delete();
        q_chars.push_back(c);
        q_sels.push_back(t);
        put_query();
    endtask

    // mostly stored names, their prefixes and overlong copies
    task automatic build_query();
        logic t;
        int e;
        int len;
        int n;
        int mode;
        t = 1'($urandom_range(0, 1));
        e = $urandom_range(0, ENTRIES - 1);
        len = stored_len(t, e);
        mode = $urandom_range(0, 99);
        q_chars.delete();
        q_sels.delete();
        if (mode < 35)
            n = len;
        else if (mode < 60)
            n = $urandom_range(1, (len > 1) ? len : 1);
        else if (mode < 70)
            n = len + $urandom_range(1, 3);
        else if (mode < 85)
            n = $urandom_range(1, 4);
        else if (mode < 92)
            n = $urandom_range(NAME_LEN + 1, NAME_LEN + 4);
        else
            n = len;
        if (n == 0)
            n = 1;
        for (int k = 0; k < n; k++) begin
            if ((mode < 70 || mode >= 92) && k < len)
                q_chars.push_back(names[t][e][k]);
            else
                q_chars.push_back(pick_char());
            q_sels.push_back(t);
        end
        if (mode >= 92 && mode < 96)
            q_chars[$urandom_range(0, n - 1)] = upnm_pkg::NUL_CHAR;
        else if (mode >= 96)
            foreach (q_sels[k]) q_sels[k] = 1'($urandom_range(0, 1));
    endtask

    // wait until every answer is in and the core has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_used(input logic [upnm_pkg::USED_W-1:0] c,
                            input logic [upnm_pkg::USED_W-1:0] i);
        cfg_we <= 1'b1;
        cfg_index <= upnm_pkg::CFG_COMMAND_USED;
        cfg_data <= c;
        @(posedge clk);
        cfg_index <= upnm_pkg::CFG_ITEM_USED;
        cfg_data <= i;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic random_phase(input int count, input logic [upnm_pkg::USED_W-1:0] c,
                                input logic [upnm_pkg::USED_W-1:0] i, input bit gaps);
        int stop;
        int r;
        int len;
        logic t;
        int e;
        settle();
        set_used(c, i);
        gaps_on = gaps;
        stop = n_items + count;
        while (n_items < stop) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                random_load();
            end else if (r < 16) begin
                t = 1'($urandom_range(0, 1));
                e = $urandom_range(0, ENTRIES - 1);
                random_name(len);
                write_entry(t, e, (len < NAME_LEN) ? len + 1 : NAME_LEN);
            end else begin
                build_query();
                put_query();
            end
        end
    endtask

    initial begin
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = upnm_pkg::CMD_LOAD;
        table_sel = '0;
        entry_index = '0;
        char_position = '0;
        char_value = '0;
        last_char = 1'b0;
        cfg_we = 1'b0;
        cfg_index = upnm_pkg::CFG_COMMAND_USED;
        cfg_data = '0;
        gaps_on = 1'b1;
        n_items = 0;
        n_loads = 0;
        n_qchars = 0;
        n_settings = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // every byte of both tables gets written before any query reads it
        for (int t = 0; t < 2; t++) begin
            for (int e = 0; e < ENTRIES; e++) begin
                if (t == 0 && e == 0)
                    fill_text("go");
                else if (t == 0 && e == 1)
                    fill_text("get");
                else if (t == 0 && e == 2)
                    fill_text("give");
                else if (t == 0 && e == 3)
                    fill_text("go");
                else if (t == 0 && e == 4)
                    fill_text("ABCDEFGHIJKLMNOP");
                else if (t == 0 && e == 5) begin
                    fill_text("xyz");
                    ebytes[0] = 8'hFF;
                    ebytes[1] = 8'h80;
                    ebytes[2] = 8'h01;
                end else if (t == 1 && e == ENTRIES - 1) begin
                    fill_text("x");
                    ebytes[0] = 8'hFF;
                end else
                    random_name(len);
                write_entry(1'(t), e, NAME_LEN);
            end
        end

        // directed: duplicate exact picks lowest index, unique prefix, ambiguous
        // prefix, query past the name, zero character, extreme bytes, a table
        // write inside a query, and a query that switches tables
        query_text(1'b0, "go");
        query_text(1'b0, "gi");
        query_text(1'b0, "g");
        query_text(1'b0, "gox");
        query_byte(1'b0, upnm_pkg::NUL_CHAR);
        query_byte(1'b0, 8'hFF);
        query_byte(1'b1, 8'hFF);
        put_item(upnm_pkg::CMD_QUERY, 1'b0, '0, '0, "g", 1'b0);
        n_qchars++;
        put_load(1'b1, 0, NAME_LEN - 1, 8'hFF);
        put_item(upnm_pkg::CMD_QUERY, 1'b0, '1, '1, "e", 1'b0);
        put_item(upnm_pkg::CMD_QUERY, 1'b0, '0, '0, "t", 1'b1);
        n_qchars += 2;
        put_item(upnm_pkg::CMD_QUERY, 1'b1, '0, '0, "g", 1'b0);
        put_item(upnm_pkg::CMD_QUERY, 1'b0, '0, '0, "o", 1'b1);
        n_qchars += 2;

        random_phase(60, 6'd32, 6'd32, 1'b1);
        random_phase(60, 6'd1, 6'd1, 1'b1);
        random_phase(60, 6'd0, 6'd63, 1'b1);
        random_phase(50, 6'd33, 6'd17, 1'b0);
        random_phase(60, upnm_pkg::USED_W'($urandom_range(1, 32)),
                     upnm_pkg::USED_W'($urandom_range(1, 32)), 1'b1);
        random_phase(60, 6'd2, 6'd31, 1'b1);
        random_phase(50, 6'd63, 6'd0, 1'b1);
        random_phase(60, 6'd32, 6'd32, 1'b0);
        settle();

        $display("sent %0d table writes and %0d query characters under %0d count settings",
                 n_loads, n_qchars, n_settings);
        $display("checked %0d answers (%0d exact, %0d unique prefix, %0d not found),",
                 n_answers, n_exact, n_prefix, n_none);
        $display("%0d failures", fail_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
